// ===== rtl/core/wialu_pkg.sv =====
// Package for the wide integer ALU: operation codes, stream field layout,
// multiplier limb sizing and the stage-advance struct.
// No dependencies.
package wialu_pkg;

	// default half width of the operands; the full word is twice this
	localparam int unsigned HALF_WIDTH_DEF = 64;

	// multiplier limb size, one 32x32 product per limb pair
	localparam int unsigned LIMB_W = 32;

	// port field widths, fixed by the stream layout
	localparam int unsigned FUNC_W   = 4;
	localparam int unsigned FIELD_W  = 64;
	localparam int unsigned SHIFT_W  = 8;
	localparam int unsigned IN_BITS  = FUNC_W + 4 * FIELD_W + SHIFT_W;
	localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = 2 * FIELD_W + 1;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// input tdata offsets, lowest field first
	localparam int unsigned OFS_FUNC  = 0;
	localparam int unsigned OFS_A_HI  = OFS_FUNC + FUNC_W;
	localparam int unsigned OFS_A_LO  = OFS_A_HI + FIELD_W;
	localparam int unsigned OFS_B_HI  = OFS_A_LO + FIELD_W;
	localparam int unsigned OFS_B_LO  = OFS_B_HI + FIELD_W;
	localparam int unsigned OFS_SHIFT = OFS_B_LO + FIELD_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD = 4'd0,
		FN_SUB = 4'd1,
		FN_AND = 4'd2,
		FN_OR  = 4'd3,
		FN_XOR = 4'd4,
		FN_NOT = 4'd5,
		FN_INC = 4'd6,
		FN_DEC = 4'd7,
		FN_SHL = 4'd8,
		FN_SHR = 4'd9,
		FN_LT  = 4'd10,
		FN_GT  = 4'd11,
		FN_MUL = 4'd12
	} func_t;

	// per-stage load enables handed to the multiplier pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

endpackage

// ===== rtl/core/wialu_mul.sv =====
// Pipelined low-half multiplier for the wide integer ALU: limb partial
// products, column sums, final sum, one register after each step.
// Depends on wialu_pkg.
module wialu_mul #(
	parameter int unsigned HALF_WIDTH = wialu_pkg::HALF_WIDTH_DEF
) (
	input  logic                      clk,
	input  wialu_pkg::adv_t           adv,
	input  logic [2*HALF_WIDTH-1:0]   a,
	input  logic [2*HALF_WIDTH-1:0]   b,
	output logic [2*HALF_WIDTH-1:0]   prod_s4
);

	localparam int unsigned FW  = 2 * HALF_WIDTH;
	localparam int unsigned LW  = wialu_pkg::LIMB_W;
	localparam int unsigned NL  = (FW + LW - 1) / LW;
	localparam int unsigned PW  = NL * LW;
	localparam int unsigned PPW = 2 * LW;
	localparam int unsigned CW  = PPW + $clog2(NL + 1);

	logic [PW-1:0]  a_pad;
	logic [PW-1:0]  b_pad;
	logic [PPW-1:0] pp_s2  [NL][NL];
	logic [CW-1:0]  col_s3 [NL];
	logic [PW-1:0]  sum;

	assign a_pad = PW'(a);
	assign b_pad = PW'(b);

	// column k holds the products of limb pairs whose indexes add to k;
	// higher columns fall outside the kept low word
	for (genvar k = 0; k < NL; k++) begin : g_col
		for (genvar t = 0; t <= k; t++) begin : g_pp
			always_ff @(posedge clk) begin
				if (adv.s2) begin
					pp_s2[k][t] <= PPW'(a_pad[LW*(k-t) +: LW]) * PPW'(b_pad[LW*t +: LW]);
				end
			end
		end

		logic [CW-1:0] col_sum;
		always_comb begin
			col_sum = '0;
			for (int t = 0; t <= k; t++) begin
				col_sum = col_sum + CW'(pp_s2[k][t]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv.s3) begin
				col_s3[k] <= col_sum;
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < NL; k++) begin
			sum = sum + (PW'(col_s3[k]) << (LW * k));
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			prod_s4 <= sum[FW-1:0];
		end
	end

endmodule

// ===== rtl/core/wide_integer_alu_128.sv =====
// Top level of the wide integer ALU: stream ports, input register, single-pass
// datapath, result pipeline. Depends on wialu_pkg and wialu_mul.
//
// Usage:
//   Requests enter on s_axis (func, operand halves, shift amount packed in
//   tdata) and each gives exactly one result on m_axis (result halves and
//   compare flag). Operands are 2*HALF_WIDTH bits wide; bits of each 64-bit
//   half above HALF_WIDTH are ignored and returned as zero.
//   Path: an accepted request passes the input register and stages s2, s3 and s4
//   to reach m_axis, the same route for every operation, so results stay in order.
//   Throughput: one request per cycle unless m_axis back-pressure has filled every
//   stage; the four-stage pipeline (input register, partial products, column sums,
//   final sum) is set by the multiplier, and the other operations ride along beside it.
//   Stall: when m_axis_tready is low the result holds in the output stage;
//   earlier stages keep advancing into empty slots and s_axis_tready falls
//   only once every stage holds a request.
//   Reset: arst_n clears all stage valid flags at once; the block accepts
//   requests as soon as reset is released.
//   Unused func codes return all zeros.
module wide_integer_alu_128 #(
	parameter int unsigned HALF_WIDTH = wialu_pkg::HALF_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// func[3:0], operand_a_hi[67:4], operand_a_lo[131:68], operand_b_hi[195:132],
	// operand_b_lo[259:196], shift_amount[267:260], zero pad[271:268]
	input  logic [wialu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// result_hi[63:0], result_lo[127:64], compare_true[128], zero pad[135:129]
	output logic [wialu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam int unsigned FW = 2 * HALF_WIDTH;
	localparam int unsigned DW = wialu_pkg::FIELD_W;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                en_s1;
	wialu_pkg::adv_t     adv;

	wialu_pkg::func_t    func_s1;
	logic [FW-1:0]       a_s1, b_s1;
	logic [wialu_pkg::SHIFT_W-1:0] sh_s1;

	logic [FW-1:0]       res;
	logic                cmp;
	logic [FW-1:0]       res_s2, res_s3, res_s4;
	logic                cmp_s2, cmp_s3, cmp_s4;
	logic                mul_s2, mul_s3, mul_s4;
	logic [FW-1:0]       prod_s4;
	logic [FW-1:0]       out_w;
	logic [DW-1:0]       out_hi, out_lo;

	// a stage loads when it is empty or its content moves on
	assign adv.s4 = !v_s4 || m_axis_tready;
	assign adv.s3 = !v_s3 || adv.s4;
	assign adv.s2 = !v_s2 || adv.s3;
	assign en_s1  = !v_s1 || adv.s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1)  v_s1 <= s_axis_tvalid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
		end
	end

	// input register: keep only the low HALF_WIDTH bits of each half
	always_ff @(posedge clk) begin
		if (en_s1) begin
			func_s1 <= wialu_pkg::func_t'(s_axis_tdata[wialu_pkg::OFS_FUNC +: wialu_pkg::FUNC_W]);
			a_s1    <= {s_axis_tdata[wialu_pkg::OFS_A_HI +: HALF_WIDTH],
			            s_axis_tdata[wialu_pkg::OFS_A_LO +: HALF_WIDTH]};
			b_s1    <= {s_axis_tdata[wialu_pkg::OFS_B_HI +: HALF_WIDTH],
			            s_axis_tdata[wialu_pkg::OFS_B_LO +: HALF_WIDTH]};
			sh_s1   <= s_axis_tdata[wialu_pkg::OFS_SHIFT +: wialu_pkg::SHIFT_W];
		end
	end

	// single-pass datapath; shifts of FW or more fall out as zero
	always_comb begin
		res = '0;
		cmp = 1'b0;
		case (func_s1)
			wialu_pkg::FN_ADD: res = a_s1 + b_s1;
			wialu_pkg::FN_SUB: res = a_s1 - b_s1;
			wialu_pkg::FN_AND: res = a_s1 & b_s1;
			wialu_pkg::FN_OR:  res = a_s1 | b_s1;
			wialu_pkg::FN_XOR: res = a_s1 ^ b_s1;
			wialu_pkg::FN_NOT: res = ~a_s1;
			wialu_pkg::FN_INC: res = a_s1 + FW'(1);
			wialu_pkg::FN_DEC: res = a_s1 - FW'(1);
			wialu_pkg::FN_SHL: res = a_s1 << sh_s1;
			wialu_pkg::FN_SHR: res = a_s1 >> sh_s1;
			wialu_pkg::FN_LT:  cmp = (a_s1 < b_s1);
			wialu_pkg::FN_GT:  cmp = (b_s1 < a_s1);
			default:           res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			res_s2 <= res;
			cmp_s2 <= cmp;
			mul_s2 <= (func_s1 == wialu_pkg::FN_MUL);
		end
		if (adv.s3) begin
			res_s3 <= res_s2;
			cmp_s3 <= cmp_s2;
			mul_s3 <= mul_s2;
		end
		if (adv.s4) begin
			res_s4 <= res_s3;
			cmp_s4 <= cmp_s3;
			mul_s4 <= mul_s3;
		end
	end

	wialu_mul #(
		.HALF_WIDTH (HALF_WIDTH)
	) u_mul (
		.clk     (clk),
		.adv     (adv),
		.a       (a_s1),
		.b       (b_s1),
		.prod_s4 (prod_s4)
	);

	assign out_w = mul_s4 ? prod_s4 : res_s4;

	always_comb begin
		out_hi = '0;
		out_lo = '0;
		out_hi[HALF_WIDTH-1:0] = out_w[FW-1:HALF_WIDTH];
		out_lo[HALF_WIDTH-1:0] = out_w[HALF_WIDTH-1:0];
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = wialu_pkg::OUT_TDATA_W'({cmp_s4, out_lo, out_hi});

endmodule

// ===== tb/wialu_checker.sv =====
// Result checker for the wide integer ALU: watches both stream channels, predicts each
// result from the accepted request and compares it field by field, in order.
// Depends on wialu_pkg.
module wialu_checker
	import wialu_pkg::*;
#(
	parameter int unsigned HALF_WIDTH = HALF_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
	output int                      mismatch_count,
	output int                      pending_count,
	output int                      checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RES_HI_OFS  = 0;
	localparam int unsigned RES_LO_OFS  = RES_HI_OFS + FIELD_W;
	localparam int unsigned RES_CMP_OFS = RES_LO_OFS + FIELD_W;
	localparam int unsigned MAX_PRINTS  = 100;

	typedef struct packed {
		logic [FIELD_W-1:0] hi;
		logic [FIELD_W-1:0] lo;
		logic               cmp;
	} alu_result_t;

	alu_result_t expected_results[$];
	int fails;
	int checked;

	function automatic alu_result_t compute_alu_result(input logic [IN_TDATA_W-1:0] req);
		logic [FUNC_W-1:0]  fn;
		logic [SHIFT_W-1:0] sh;
		logic [FIELD_W-1:0] half_mask;
		logic [127:0]       full_mask;
		logic [127:0]       a;
		logic [127:0]       b;
		logic [127:0]       r;
		alu_result_t        res;
		fn = req[OFS_FUNC +: FUNC_W];
		sh = req[OFS_SHIFT +: SHIFT_W];
		half_mask = (HALF_WIDTH >= FIELD_W) ? '1 : ((64'd1 << HALF_WIDTH) - 64'd1);
		full_mask = (HALF_WIDTH >= FIELD_W) ? '1 : ((128'd1 << (2 * HALF_WIDTH)) - 128'd1);
		// narrow halves drop their upper bits before they are joined
		a = ({64'd0, req[OFS_A_HI +: FIELD_W] & half_mask} << HALF_WIDTH)
			| {64'd0, req[OFS_A_LO +: FIELD_W] & half_mask};
		b = ({64'd0, req[OFS_B_HI +: FIELD_W] & half_mask} << HALF_WIDTH)
			| {64'd0, req[OFS_B_LO +: FIELD_W] & half_mask};
		r = '0;
		res = '0;
		case (fn)
			FN_ADD: r = a + b;
			FN_SUB: r = a - b;
			FN_AND: r = a & b;
			FN_OR:  r = a | b;
			FN_XOR: r = a ^ b;
			FN_NOT: r = ~a;
			FN_INC: r = a + 128'd1;
			FN_DEC: r = a - 128'd1;
			FN_SHL: r = (sh >= 2 * HALF_WIDTH) ? '0 : (a << sh);
			FN_SHR: r = (sh >= 2 * HALF_WIDTH) ? '0 : (a >> sh);
			FN_LT:  res.cmp = (a < b);
			FN_GT:  res.cmp = (a > b);
			FN_MUL: r = a * b;
			default: ;
		endcase
		r = r & full_mask;
		res.hi = FIELD_W'(r >> HALF_WIDTH) & half_mask;
		res.lo = r[FIELD_W-1:0] & half_mask;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [FIELD_W-1:0] got_v,
		input logic [FIELD_W-1:0] want_v);
		fails++;
		if (fails <= MAX_PRINTS) begin
			$display("[%0t] mismatch on %s after %0d results: got %h, expected %h",
				$time, field, checked, got_v, want_v);
		end
	endtask

	always @(posedge clk) begin : watch
		alu_result_t got;
		alu_result_t want;
		if (arst_n) begin
			// push before pop so a result in the same cycle as its request still lines up
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(compute_alu_result(s_axis_tdata));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.hi  = m_axis_tdata[RES_HI_OFS +: FIELD_W];
				got.lo  = m_axis_tdata[RES_LO_OFS +: FIELD_W];
				got.cmp = m_axis_tdata[RES_CMP_OFS];
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding", got.lo, '0);
				end else begin
					want = expected_results.pop_front();
					if (got.hi !== want.hi) begin
						report_mismatch("result_hi", got.hi, want.hi);
					end
					if (got.lo !== want.lo) begin
						report_mismatch("result_lo", got.lo, want.lo);
					end
					if (got.cmp !== want.cmp) begin
						report_mismatch("compare_true", FIELD_W'(got.cmp), FIELD_W'(want.cmp));
					end
					checked++;
				end
			end
		end
		mismatch_count <= fails;
		pending_count  <= expected_results.size();
		checked_count  <= checked;
	end

endmodule

// ===== tb/tb_wide_integer_alu_128.sv =====
// Top of the wide integer ALU testbench: clock, reset, request stimulus, result sink
// and verdict. Depends on wialu_pkg, wide_integer_alu_128 and wialu_checker.
module tb_wide_integer_alu_128;
	timeunit 1ns;
	timeprecision 1ps;

	import wialu_pkg::*;

	localparam int unsigned HW              = HALF_WIDTH_DEF;
	localparam int unsigned RX_HOLD_CYCLES  = 64;
	localparam int unsigned SETTLE_CYCLES   = 10;
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd13;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;
	localparam logic [FIELD_W-1:0] ONES = '1;
	localparam logic [FIELD_W-1:0] MSB  = 64'h8000_0000_0000_0000;
	localparam logic [FIELD_W-1:0] ALT  = 64'hAAAA_AAAA_AAAA_AAAA;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	int  mismatch_count;
	int  pending_count;
	int  checked_count;
	int  requests_sent;
	bit  tx_idle_en;
	bit  rx_idle_en;
	bit  rx_hold_pending;

	wide_integer_alu_128 #(.HALF_WIDTH(HW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	wialu_checker #(.HALF_WIDTH(HW)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [IN_TDATA_W-1:0] pack_req(input logic [FUNC_W-1:0] fn,
		input logic [FIELD_W-1:0] a_hi, input logic [FIELD_W-1:0] a_lo,
		input logic [FIELD_W-1:0] b_hi, input logic [FIELD_W-1:0] b_lo,
		input logic [SHIFT_W-1:0] sh);
		logic [IN_TDATA_W-1:0] req;
		req = '0;
		req[OFS_FUNC +: FUNC_W]   = fn;
		req[OFS_A_HI +: FIELD_W]  = a_hi;
		req[OFS_A_LO +: FIELD_W]  = a_lo;
		req[OFS_B_HI +: FIELD_W]  = b_hi;
		req[OFS_B_LO +: FIELD_W]  = b_lo;
		req[OFS_SHIFT +: SHIFT_W] = sh;
		return req;
	endfunction

	// half full-random halves, the rest zero, all ones, small values and single-bit or single-zero-bit patterns
	function automatic logic [FIELD_W-1:0] rand_half();
		int unsigned pick;
		int unsigned bitpos;
		pick = $urandom_range(0, 9);
		bitpos = $urandom_range(0, FIELD_W - 1);
		case (pick)
			0: return '0;
			1: return ONES;
			2: return FIELD_W'($urandom_range(0, 15));
			3: return 64'd1 << bitpos;
			4: return ~(64'd1 << bitpos);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_req(input logic [IN_TDATA_W-1:0] req);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tdata  <= req;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
	endtask

	task automatic send_random();
		logic [FUNC_W-1:0]  fn;
		logic [FIELD_W-1:0] a_hi;
		logic [FIELD_W-1:0] a_lo;
		logic [FIELD_W-1:0] b_hi;
		logic [FIELD_W-1:0] b_lo;
		logic [SHIFT_W-1:0] sh;
		fn   = FUNC_W'($urandom_range(0, FN_SPARE_HI));
		a_hi = rand_half();
		a_lo = rand_half();
		b_hi = rand_half();
		b_lo = rand_half();
		// tie the high halves often so compares get decided by the low halves
		if (fn == FN_LT || fn == FN_GT) begin
			case ($urandom_range(0, 5))
				0, 1: b_hi = a_hi;
				2: begin
					b_hi = a_hi;
					b_lo = a_lo;
				end
				default: ;
			endcase
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0: sh = 8'd0;
				1: sh = 8'd63;
				2: sh = 8'd64;
				3: sh = 8'd127;
				4: sh = 8'd128;
				default: sh = 8'd255;
			endcase
		end else begin
			sh = SHIFT_W'($urandom);
		end
		send_req(pack_req(fn, a_hi, a_lo, b_hi, b_lo, sh));
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic run_directed();
		send_req(pack_req(FN_ADD, ONES, ONES, '0, 64'd1, 8'hFF));   // wraps to zero
		send_req(pack_req(FN_ADD, '0, ONES, '0, 64'd1, '0));        // carry into high half
		send_req(pack_req(FN_SUB, '0, '0, '0, 64'd1, '0));          // wraps to all ones
		send_req(pack_req(FN_SUB, 64'd1, '0, '0, 64'd1, '0));       // borrow from high half
		send_req(pack_req(FN_AND, ONES, ALT, ~ALT, ONES, '0));
		send_req(pack_req(FN_OR, ALT, '0, ~ALT, '0, '0));
		send_req(pack_req(FN_XOR, ONES, ALT, ALT, ONES, '0));
		send_req(pack_req(FN_NOT, '0, '0, ONES, ONES, 8'hFF));
		send_req(pack_req(FN_INC, ONES, ONES, '0, '0, '0));
		send_req(pack_req(FN_INC, '0, ONES, '0, '0, '0));
		send_req(pack_req(FN_DEC, '0, '0, '0, '0, '0));
		send_req(pack_req(FN_DEC, 64'd1, '0, '0, '0, '0));
		send_req(pack_req(FN_SHL, MSB | 64'd1, ONES, '0, '0, 8'd0));
		send_req(pack_req(FN_SHL, MSB | 64'd1, ONES, '0, '0, 8'd64));
		send_req(pack_req(FN_SHL, ONES, ONES, '0, '0, 8'd127));
		send_req(pack_req(FN_SHL, ONES, ONES, '0, '0, 8'd128));    // long shift
		send_req(pack_req(FN_SHR, MSB, 64'd1, '0, '0, 8'd65));
		send_req(pack_req(FN_SHR, ONES, ONES, '0, '0, 8'd255));    // long shift
		send_req(pack_req(FN_LT, '0, ONES, 64'd1, '0, '0));        // high halves decide
		send_req(pack_req(FN_LT, ALT, 64'd5, ALT, 64'd6, '0));     // low halves decide
		send_req(pack_req(FN_LT, ONES, ONES, ONES, ONES, '0));     // equal gives 0
		send_req(pack_req(FN_GT, 64'd1, '0, '0, ONES, '0));
		send_req(pack_req(FN_GT, ALT, 64'd6, ALT, 64'd5, '0));
		send_req(pack_req(FN_MUL, ONES, ONES, ONES, ONES, '0));
		send_req(pack_req(FN_MUL, 64'd1, ONES, 64'd3, ONES, '0));
		send_req(pack_req(FN_SPARE_LO, ONES, ONES, ONES, ONES, 8'hFF));
		send_req(pack_req(FN_SPARE_HI, ONES, ONES, ONES, ONES, 8'hFF));
	endtask

	// result sink: random back-pressure bursts, plus one long hold-off on request
	initial begin : result_sink
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_pending) begin
				rx_hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : stimulus
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		tx_idle_en      = 1'b0;
		rx_idle_en      = 1'b0;
		rx_hold_pending = 1'b0;
		requests_sent   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (350) send_random();

		// hold requests until every result is back
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// stream back-to-back while the sink holds off, so the pipeline fills
		tx_idle_en = 1'b0;
		rx_hold_pending = 1'b1;
		repeat (100) send_random();

		tx_idle_en = 1'b1;
		repeat (450) send_random();

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (200) send_random();

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests over all sixteen func codes: carries, borrows, long shifts,",
			requests_sent);
		$display("split-half compares and spare codes, %0d results checked under back-pressure.",
			checked_count);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wialu_pkg.sv
rtl/core/wialu_mul.sv
rtl/core/wide_integer_alu_128.sv
tb/wialu_checker.sv
tb/tb_wide_integer_alu_128.sv
